### hw/rtl/pspe_pkg.sv
// Shared constants, register codes and controller/datapath interface types
// for the polyline stroke pattern expander. No dependencies.
`default_nettype none

package pspe_pkg;

    // Pattern limits
    localparam int MAX_PIECES = 64;
    localparam int EPSILON_Q8 = 1;

    localparam int PIECE_AW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int CNT_W    = $clog2(MAX_PIECES + 1);

    // Datapath widths
    localparam int COORD_W = 24;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int PIECE_W = 4 * COORD_W;

    // Iteration counts of the shared square root and divider
    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 50;

    // Pattern modes
    localparam logic [1:0] MODE_SOLID  = 2'd0;
    localparam logic [1:0] MODE_DASH   = 2'd1;
    localparam logic [1:0] MODE_DOT    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [IDX_W-1:0] REG_STROKE_W   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DASH_LEN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAP_LEN    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DOT_GAP    = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_STROKE_W = 16'd256;
    localparam logic [CFG_W-1:0] RST_DASH_LEN = 16'd2048;
    localparam logic [CFG_W-1:0] RST_GAP_LEN  = 16'd1024;
    localparam logic [CFG_W-1:0] RST_DOT_GAP  = 16'd512;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_DXX,
        MUL_DYY,
        MUL_LERP
    } mul_op_t;

    typedef struct packed {
        logic    line_start;
        logic    take_seg;
        mul_op_t mul_op;
        logic    sq_load;
        logic    sq_add;
        logic    sqrt_step;
        logic    div_start_pos;
        logic    div_start_dot;
        logic    div_start_lerp;
        logic    div_step;
        logic    pos_load;
        logic    dash_adv;
        logic    set_drop;
        logic    dot_load;
        logic    dot_skip;
        logic    dot_adv;
        logic    lerp_init;
        logic    lerp_res;
        logic    put_solid;
        logic    put_piece;
        logic    dist_adv;
        logic    out_load;
        logic    out_adv;
    } ctl_cmd_t;

    typedef struct packed {
        logic       line_start;
        logic [1:0] mode;
        logic       len_small;
        logic       dl_pos;
        logic       dot_ok;
        logic       off_le_len;
        logic       it_zero;
        logic       d_ge_len;
        logic       dash_emit;
        logic       n_full;
        logic       n_zero;
        logic       dot_done;
        logic       lerp_last;
        logic       out_last;
    } ctl_stat_t;

endpackage

`default_nettype wire

### hw/rtl/pspe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pspe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                           clk,
    input  wire logic                                           we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]                               wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic      [WIDTH-1:0]                               rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/pspe_dp.sv
// Datapath of the stroke pattern expander: configuration, vertex state,
// shared multiplier, square root and divider, dash/dot walk. Uses pspe_pkg.
`default_nettype none

module pspe_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pspe_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [pspe_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic signed [23:0]                vertex_x,
    input  wire logic signed [23:0]                vertex_y,
    input  wire logic                              starts_line,
    input  wire pspe_pkg::ctl_cmd_t                cmd,
    output pspe_pkg::ctl_stat_t                    st,
    output logic                                   ram_we,
    output logic [pspe_pkg::PIECE_AW-1:0]          ram_waddr,
    output logic [pspe_pkg::PIECE_W-1:0]           ram_wdata,
    output logic [pspe_pkg::PIECE_AW-1:0]          ram_raddr,
    input  wire logic [pspe_pkg::PIECE_W-1:0]      ram_rdata,
    output logic signed [23:0]                     piece_start_x,
    output logic signed [23:0]                     piece_start_y,
    output logic signed [23:0]                     piece_end_x,
    output logic signed [23:0]                     piece_end_y,
    output logic                                   last_piece,
    output logic                                   pieces_dropped
);
    localparam int CW = pspe_pkg::CNT_W;

    // Configuration
    logic [1:0]  mode_reg;
    logic [15:0] sw_reg, dash_reg, gap_reg, dgap_reg;

    // Vertex and distance state
    logic signed [23:0] prev_x_reg, prev_y_reg;
    logic               have_prev_reg;
    logic [31:0]        dist_reg, next_dot_reg;

    // Segment
    logic signed [23:0] ax_reg, ay_reg;
    logic signed [24:0] dx_reg, dy_reg;

    // Multiplier
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] mul_reg;

    // Square root
    logic [49:0] sq_reg;
    logic [25:0] sr_rem_reg;
    logic [24:0] len_reg;
    logic [27:0] sr_sh, sr_trial, sr_diff;
    logic        sr_fit;

    logic [5:0]  it_reg;

    // Divider
    logic [49:0]        dv_quo_reg;
    logic [24:0]        dv_rem_reg, dv_den_reg;
    logic               dv_neg_reg;
    logic [25:0]        dv_sh, dv_diff;
    logic               dv_ge;
    logic signed [51:0] mag_full;
    logic [49:0]        lerp_dvd;
    logic               q_ge;

    // Pattern derived values
    logic [16:0] pat, steplen, dl_s;
    logic [15:0] dl;
    logic        dl_pos;
    logic [31:0] nd_load;

    // Walk state
    logic [16:0] pos_reg;
    logic [25:0] d_reg;
    logic [24:0] pd0_reg, pd1_reg;
    logic        in_dash;
    logic [16:0] remv;
    logic [24:0] left, step, pos_sum;
    logic [16:0] pos_next;
    logic [25:0] d_sum;
    logic [CW-1:0] n_reg, emit_reg, rd_reg, rd_inc;
    logic          drop_reg;
    logic [1:0]    lidx_reg;

    // Interpolated points
    logic signed [23:0] px0_reg, py0_reg, px1_reg, py1_reg;
    logic signed [23:0] lr_a;
    logic [25:0]        lr_base, lr_res, lr_q;

    // Output beat
    logic [23:0] osx_reg, osy_reg, oex_reg, oey_reg;
    logic        olast_reg, odrop_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pspe_pkg::MODE_SOLID;
            sw_reg   <= pspe_pkg::RST_STROKE_W;
            dash_reg <= pspe_pkg::RST_DASH_LEN;
            gap_reg  <= pspe_pkg::RST_GAP_LEN;
            dgap_reg <= pspe_pkg::RST_DOT_GAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pspe_pkg::REG_MODE:     mode_reg <= cfg_data[1:0];
                pspe_pkg::REG_STROKE_W: sw_reg   <= cfg_data;
                pspe_pkg::REG_DASH_LEN: dash_reg <= cfg_data;
                pspe_pkg::REG_GAP_LEN:  gap_reg  <= cfg_data;
                pspe_pkg::REG_DOT_GAP:  dgap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pattern lengths
    assign pat     = {1'b0, dash_reg} + {1'b0, gap_reg};
    assign steplen = {1'b0, sw_reg} + {1'b0, dgap_reg};
    assign dl_s    = {1'b0, dash_reg} - {1'b0, sw_reg};
    assign dl      = dl_s[15:0];
    assign dl_pos  = !dl_s[16] && (dl_s != 17'd0);
    assign nd_load = {15'd0, steplen} - {7'd0, dv_rem_reg};

    // Track previous vertex, travelled distance and next dot offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            dist_reg      <= '0;
            next_dot_reg  <= '0;
        end
        else
        begin
            if (cmd.line_start)
            begin
                prev_x_reg    <= vertex_x;
                prev_y_reg    <= vertex_y;
                have_prev_reg <= 1'b1;
                dist_reg      <= '0;
                next_dot_reg  <= '0;
            end
            else if (cmd.take_seg)
            begin
                prev_x_reg <= vertex_x;
                prev_y_reg <= vertex_y;
            end
            if (cmd.dist_adv)
            begin
                dist_reg <= dist_reg + {7'd0, len_reg};
            end
            if (cmd.dot_load)
            begin
                next_dot_reg <= nd_load;
            end
            else if (cmd.dot_skip)
            begin
                next_dot_reg <= next_dot_reg - {7'd0, len_reg};
            end
        end
    end

    // Latch segment start and deltas
    always_ff @(posedge clk)
    begin
        if (cmd.take_seg)
        begin
            ax_reg <= prev_x_reg;
            ay_reg <= prev_y_reg;
            dx_reg <= {vertex_x[23], vertex_x} - {prev_x_reg[23], prev_x_reg};
            dy_reg <= {vertex_y[23], vertex_y} - {prev_y_reg[23], prev_y_reg};
        end
    end

    // Select multiplier operands
    always_comb
    begin
        unique case (cmd.mul_op)
            pspe_pkg::MUL_DXX:
            begin
                mul_a = {dx_reg[24], dx_reg};
                mul_b = {dx_reg[24], dx_reg};
            end
            pspe_pkg::MUL_DYY:
            begin
                mul_a = {dy_reg[24], dy_reg};
                mul_b = {dy_reg[24], dy_reg};
            end
            pspe_pkg::MUL_LERP:
            begin
                mul_a = lidx_reg[0] ? {dy_reg[24], dy_reg} : {dx_reg[24], dx_reg};
                mul_b = $signed({1'b0, (lidx_reg[1] ? pd1_reg : pd0_reg)});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_op != pspe_pkg::MUL_IDLE)
        begin
            mul_reg <= mul_a * mul_b;
        end
    end

    // Square root: two radicand bits per step
    assign sr_sh    = {sr_rem_reg, sq_reg[49:48]};
    assign sr_trial = {1'b0, len_reg, 2'b01};
    assign sr_fit   = sr_sh >= sr_trial;
    assign sr_diff  = sr_sh - sr_trial;

    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
        begin
            sq_reg <= mul_reg[49:0];
        end
        else if (cmd.sq_add)
        begin
            sq_reg     <= sq_reg + mul_reg[49:0];
            sr_rem_reg <= '0;
            len_reg    <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_reg     <= {sq_reg[47:0], 2'b00};
            sr_rem_reg <= sr_fit ? sr_diff[25:0] : sr_sh[25:0];
            len_reg    <= {len_reg[23:0], sr_fit};
        end
    end

    // Iteration counter shared by square root and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg <= '0;
        end
        else if (cmd.sq_add)
        begin
            it_reg <= 6'(pspe_pkg::SQRT_STEPS - 1);
        end
        else if (cmd.div_start_pos || cmd.div_start_dot || cmd.div_start_lerp)
        begin
            it_reg <= 6'(pspe_pkg::DIV_STEPS - 1);
        end
        else if (cmd.sqrt_step || cmd.div_step)
        begin
            it_reg <= it_reg - 6'd1;
        end
    end

    // Divider: restoring, one quotient bit per step
    assign mag_full = mul_reg[51] ? -mul_reg : mul_reg;
    assign lerp_dvd = mag_full[49:0] + {26'd0, len_reg[24:1]};
    assign dv_sh    = {dv_rem_reg, dv_quo_reg[49]};
    assign dv_ge    = dv_sh >= {1'b0, dv_den_reg};
    assign dv_diff  = dv_sh - {1'b0, dv_den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start_pos)
        begin
            dv_quo_reg <= {18'd0, dist_reg};
            dv_den_reg <= {8'd0, pat};
            dv_rem_reg <= '0;
        end
        else if (cmd.div_start_dot)
        begin
            dv_quo_reg <= {25'd0, len_reg - next_dot_reg[24:0]};
            dv_den_reg <= {8'd0, steplen};
            dv_rem_reg <= '0;
        end
        else if (cmd.div_start_lerp)
        begin
            dv_quo_reg <= lerp_dvd;
            dv_den_reg <= len_reg;
            dv_rem_reg <= '0;
            dv_neg_reg <= mul_reg[51];
        end
        else if (cmd.div_step)
        begin
            dv_rem_reg <= dv_ge ? dv_diff[24:0] : dv_sh[24:0];
            dv_quo_reg <= {dv_quo_reg[48:0], dv_ge};
        end
    end

    // Dash walk: distance to the next pattern edge, clipped to the segment
    assign in_dash  = pos_reg < {1'b0, dl};
    assign remv     = in_dash ? ({1'b0, dl} - pos_reg) : (pat - pos_reg);
    assign left     = len_reg - d_reg[24:0];
    assign step     = ({8'd0, remv} < left) ? {8'd0, remv} : left;
    assign pos_sum  = {8'd0, pos_reg} + step;
    assign pos_next = (pos_sum == {8'd0, pat}) ? 17'd0 : pos_sum[16:0];
    assign d_sum    = d_reg + {1'b0, step};
    assign q_ge     = dv_quo_reg >= 50'(pspe_pkg::MAX_PIECES);
    assign rd_inc   = rd_reg + CW'(1);

    // Advance walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            emit_reg <= '0;
            rd_reg   <= '0;
            drop_reg <= 1'b0;
            lidx_reg <= '0;
        end
        else
        begin
            if (cmd.take_seg)
            begin
                n_reg    <= '0;
                rd_reg   <= '0;
                drop_reg <= 1'b0;
            end
            else if (cmd.put_solid)
            begin
                n_reg <= CW'(1);
            end
            else if (cmd.put_piece)
            begin
                n_reg <= n_reg + CW'(1);
            end
            if (cmd.set_drop)
            begin
                drop_reg <= 1'b1;
            end
            else if (cmd.dot_load)
            begin
                drop_reg <= q_ge;
                emit_reg <= q_ge ? CW'(pspe_pkg::MAX_PIECES)
                                 : (dv_quo_reg[CW-1:0] + CW'(1));
            end
            if (cmd.lerp_init)
            begin
                lidx_reg <= '0;
            end
            else if (cmd.lerp_res)
            begin
                lidx_reg <= lidx_reg + 2'd1;
            end
            if (cmd.out_adv)
            begin
                rd_reg <= rd_inc;
            end
        end
    end

    // Advance walk position and piece distances
    always_ff @(posedge clk)
    begin
        if (cmd.pos_load)
        begin
            pos_reg <= dv_rem_reg[16:0];
            d_reg   <= '0;
        end
        else if (cmd.dash_adv)
        begin
            d_reg   <= d_sum;
            pos_reg <= pos_next;
            if (st.dash_emit)
            begin
                pd0_reg <= d_reg[24:0];
                pd1_reg <= d_sum[24:0];
            end
        end
        else if (cmd.dot_load)
        begin
            d_reg <= {1'b0, next_dot_reg[24:0]};
        end
        else if (cmd.dot_adv)
        begin
            pd0_reg <= d_reg[24:0];
            d_reg   <= d_reg + {9'd0, steplen};
        end
    end

    // Offset the rounded quotient into a coordinate
    assign lr_a    = lidx_reg[0] ? ay_reg : ax_reg;
    assign lr_base = {{2{lr_a[23]}}, lr_a};
    assign lr_q    = dv_quo_reg[25:0];
    assign lr_res  = dv_neg_reg ? (lr_base - lr_q) : (lr_base + lr_q);

    always_ff @(posedge clk)
    begin
        if (cmd.lerp_res)
        begin
            unique case (lidx_reg)
                2'd0: px0_reg <= lr_res[23:0];
                2'd1: py0_reg <= lr_res[23:0];
                2'd2: px1_reg <= lr_res[23:0];
                default: py1_reg <= lr_res[23:0];
            endcase
        end
    end

    // Piece buffer write and read
    assign ram_we    = cmd.put_solid || cmd.put_piece;
    assign ram_waddr = cmd.put_solid ? '0 : n_reg[pspe_pkg::PIECE_AW-1:0];
    assign ram_raddr = rd_reg[pspe_pkg::PIECE_AW-1:0];

    always_comb
    begin
        if (cmd.put_solid)
        begin
            ram_wdata = {ax_reg, ay_reg, prev_x_reg, prev_y_reg};
        end
        else if (mode_reg == pspe_pkg::MODE_DOT)
        begin
            ram_wdata = {px0_reg, py0_reg, px0_reg, py0_reg};
        end
        else
        begin
            ram_wdata = {px0_reg, py0_reg, px1_reg, py1_reg};
        end
    end

    // Load output beat
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            {osx_reg, osy_reg, oex_reg, oey_reg} <= ram_rdata;
            olast_reg <= (rd_inc == n_reg);
            odrop_reg <= drop_reg;
        end
    end

    assign piece_start_x  = osx_reg;
    assign piece_start_y  = osy_reg;
    assign piece_end_x    = oex_reg;
    assign piece_end_y    = oey_reg;
    assign last_piece     = olast_reg;
    assign pieces_dropped = odrop_reg;

    // Status to the controller
    always_comb
    begin
        st.line_start = starts_line || !have_prev_reg;
        st.mode       = mode_reg;
        st.len_small  = len_reg <= 25'(pspe_pkg::EPSILON_Q8);
        st.dl_pos     = dl_pos;
        st.dot_ok     = (sw_reg > 16'(2 * pspe_pkg::EPSILON_Q8))
                        && (steplen > 17'(pspe_pkg::EPSILON_Q8));
        st.off_le_len = next_dot_reg <= {7'd0, len_reg};
        st.it_zero    = it_reg == 6'd0;
        st.d_ge_len   = d_reg >= {1'b0, len_reg};
        st.dash_emit  = in_dash && (step > 25'(pspe_pkg::EPSILON_Q8));
        st.n_full     = n_reg == CW'(pspe_pkg::MAX_PIECES);
        st.n_zero     = n_reg == '0;
        st.dot_done   = n_reg == emit_reg;
        st.lerp_last  = (mode_reg == pspe_pkg::MODE_DOT) ? (lidx_reg == 2'd1)
                                                         : (lidx_reg == 2'd3);
        st.out_last   = olast_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/pspe_ctrl.sv
// Controller of the stroke pattern expander: sequences segment length,
// pattern walk, interpolation and output beats. Uses pspe_pkg.
`default_nettype none

module pspe_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire pspe_pkg::ctl_stat_t  st,
    output pspe_pkg::ctl_cmd_t        cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_DISP,
        S_DIVP, S_POSL, S_DASH, S_DIVD, S_DOTL, S_DOT,
        S_LMUL, S_LDIV0, S_LDIV, S_LRES, S_LWR,
        S_FIN, S_ORD, S_OLD, S_OWAIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.line_start)
                    begin
                        cmd.line_start = 1'b1;
                    end
                    else
                    begin
                        cmd.take_seg = 1'b1;
                        state_next   = S_SQ1;
                    end
                end
            end
            S_SQ1:
            begin
                cmd.mul_op = pspe_pkg::MUL_DXX;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.sq_load = 1'b1;
                cmd.mul_op  = pspe_pkg::MUL_DYY;
                state_next  = S_SQ3;
            end
            S_SQ3:
            begin
                cmd.sq_add = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (st.it_zero)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (st.mode)
                    pspe_pkg::MODE_SOLID:
                    begin
                        cmd.put_solid = 1'b1;
                        state_next    = S_FIN;
                    end
                    pspe_pkg::MODE_DASH:
                    begin
                        if (st.len_small)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (st.dl_pos)
                        begin
                            cmd.div_start_pos = 1'b1;
                            state_next        = S_DIVP;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    pspe_pkg::MODE_DOT:
                    begin
                        if (st.len_small)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (!st.dot_ok)
                        begin
                            state_next = S_FIN;
                        end
                        else if (st.off_le_len)
                        begin
                            cmd.div_start_dot = 1'b1;
                            state_next        = S_DIVD;
                        end
                        else
                        begin
                            cmd.dot_skip = 1'b1;
                            state_next   = S_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_DIVP:
            begin
                cmd.div_step = 1'b1;
                if (st.it_zero)
                begin
                    state_next = S_POSL;
                end
            end
            S_POSL:
            begin
                cmd.pos_load = 1'b1;
                state_next   = S_DASH;
            end
            S_DASH:
            begin
                if (st.d_ge_len)
                begin
                    state_next = S_FIN;
                end
                else if (st.dash_emit && st.n_full)
                begin
                    cmd.set_drop = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.dash_adv = 1'b1;
                    if (st.dash_emit)
                    begin
                        cmd.lerp_init = 1'b1;
                        state_next    = S_LMUL;
                    end
                end
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                if (st.it_zero)
                begin
                    state_next = S_DOTL;
                end
            end
            S_DOTL:
            begin
                cmd.dot_load = 1'b1;
                state_next   = S_DOT;
            end
            S_DOT:
            begin
                if (st.dot_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.dot_adv   = 1'b1;
                    cmd.lerp_init = 1'b1;
                    state_next    = S_LMUL;
                end
            end
            S_LMUL:
            begin
                cmd.mul_op = pspe_pkg::MUL_LERP;
                state_next = S_LDIV0;
            end
            S_LDIV0:
            begin
                cmd.div_start_lerp = 1'b1;
                state_next         = S_LDIV;
            end
            S_LDIV:
            begin
                cmd.div_step = 1'b1;
                if (st.it_zero)
                begin
                    state_next = S_LRES;
                end
            end
            S_LRES:
            begin
                cmd.lerp_res = 1'b1;
                state_next   = st.lerp_last ? S_LWR : S_LMUL;
            end
            S_LWR:
            begin
                cmd.put_piece = 1'b1;
                state_next    = (st.mode == pspe_pkg::MODE_DOT) ? S_DOT : S_DASH;
            end
            S_FIN:
            begin
                cmd.dist_adv = 1'b1;
                state_next   = st.n_zero ? S_IDLE : S_ORD;
            end
            S_ORD:
            begin
                state_next = S_OLD;
            end
            S_OLD:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    cmd.out_adv    = 1'b1;
                    state_next     = st.out_last ? S_IDLE : S_ORD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/polyline_stroke_pattern_expander_core.sv
// Top level of the polyline stroke pattern expander.
// Joins pspe_ctrl, pspe_dp and the piece buffer pspe_ram; uses pspe_pkg.
`default_nettype none

// Takes one vertex per input beat and returns the stroke pieces of the
// segment it closes: the segment itself (solid), the dash pieces (dashed)
// or dot centres (dotted), up to 64 per vertex, with last_piece on the final
// beat and pieces_dropped on every beat of a clipped segment. One vertex is
// in work at a time. A vertex that starts a line only records the start point.
// Any other vertex first gets its segment length (25-step square root),
// then the dash phase or dot count division, then each interpolated
// coordinate on the shared 50-step divider. The dash walk moves one pattern
// edge per step, and each output beat is read from the piece buffer and held
// while out_stall is high.
module polyline_stroke_pattern_expander_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pspe_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [pspe_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [23:0]              vertex_x,
    input  wire logic signed [23:0]              vertex_y,
    input  wire logic                            starts_line,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [23:0]                   piece_start_x,
    output logic signed [23:0]                   piece_start_y,
    output logic signed [23:0]                   piece_end_x,
    output logic signed [23:0]                   piece_end_y,
    output logic                                 last_piece,
    output logic                                 pieces_dropped
);
    pspe_pkg::ctl_cmd_t  cmd;
    pspe_pkg::ctl_stat_t st;

    logic                            ram_we;
    logic [pspe_pkg::PIECE_AW-1:0]   ram_waddr, ram_raddr;
    logic [pspe_pkg::PIECE_W-1:0]    ram_wdata, ram_rdata;

    // Sequencer
    pspe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // Arithmetic and state
    pspe_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .starts_line    (starts_line),
        .cmd            (cmd),
        .st             (st),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .piece_start_x  (piece_start_x),
        .piece_start_y  (piece_start_y),
        .piece_end_x    (piece_end_x),
        .piece_end_y    (piece_end_y),
        .last_piece     (last_piece),
        .pieces_dropped (pieces_dropped)
    );

    // Piece buffer
    pspe_ram #(
        .WIDTH (pspe_pkg::PIECE_W),
        .DEPTH (pspe_pkg::MAX_PIECES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
